// ===== src/assert_macros.svh =====
// Assertion macros used by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== src/lpmd_pkg.sv =====
// Types and constants of the length-prefixed message deframer.
package lpmd_pkg;

    localparam int unsigned HDR_LEN    = 25;
    localparam int unsigned HDR_IDX_W  = 5;
    localparam logic [HDR_IDX_W-1:0] OPCODE_POS = HDR_IDX_W'(24);

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [15:0] attempt;
        logic [7:0]  tracked;
        logic [7:0]  reliable;
        logic [63:0] source_id;
        logic [63:0] sequence_num;
        logic [31:0] payload_length;
    } hdr_fields_t;

endpackage

// ===== src/lpmd_hdr_capture.sv =====
// Header byte position counter and big-endian field shift registers.
module lpmd_hdr_capture
    import lpmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        take,
    input  logic [7:0]  data_byte,
    output hdr_fields_t hdr,
    output logic        opcode_slot
);

    logic [HDR_IDX_W-1:0] idx_reg;
    logic [HDR_IDX_W-1:0] idx_next;
    logic [HDR_IDX_W-1:0] pos;
    hdr_fields_t          hdr_reg;
    hdr_fields_t          hdr_next;

    // Fold any out-of-range position back to the start of a header.
    assign pos         = (idx_reg >= HDR_IDX_W'(HDR_LEN)) ? '0 : idx_reg;
    assign opcode_slot = (pos == OPCODE_POS);
    assign hdr         = hdr_reg;

    always_comb begin
        idx_next = idx_reg;
        hdr_next = hdr_reg;
        if (take) begin
            if (opcode_slot) begin
                idx_next = '0;
            end else begin
                idx_next = pos + HDR_IDX_W'(1);
                if (pos <= HDR_IDX_W'(1)) begin
                    hdr_next.attempt = {hdr_reg.attempt[7:0], data_byte};
                end else if (pos == HDR_IDX_W'(2)) begin
                    hdr_next.tracked = data_byte;
                end else if (pos == HDR_IDX_W'(3)) begin
                    hdr_next.reliable = data_byte;
                end else if (pos <= HDR_IDX_W'(11)) begin
                    hdr_next.source_id = {hdr_reg.source_id[55:0], data_byte};
                end else if (pos <= HDR_IDX_W'(19)) begin
                    hdr_next.sequence_num = {hdr_reg.sequence_num[55:0], data_byte};
                end else begin
                    hdr_next.payload_length = {hdr_reg.payload_length[23:0], data_byte};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            hdr_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            hdr_reg <= hdr_next;
        end
    end

endmodule

// ===== src/length_prefixed_message_deframer.sv =====
// Length-prefixed message deframer: 25-byte header then payload bytes.
// A result is loaded into the output register in the cycle after the byte that
// causes it is accepted. Throughput: one byte per cycle while m_ready is high, set
// by the single output register that refills in the same cycle it is drained.
// Reset (synchronous, active low) returns to header byte 0 with no result held.
`include "assert_macros.svh"
module length_prefixed_message_deframer
    import lpmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [15:0] m_attempt,
    output logic [7:0]  m_tracked,
    output logic [7:0]  m_reliable,
    output logic [63:0] m_source_id,
    output logic [63:0] m_sequence_res,
    output logic [31:0] m_payload_length,
    output logic [7:0]  m_opcode,
    output logic [7:0]  m_payload_byte,
    output logic        m_last
);

    hdr_fields_t hdr;
    logic        opcode_slot;
    logic        accept;
    logic        pay_mode;
    logic        hdr_take;
    logic        produce;

    logic        in_payload_reg, in_payload_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] remaining_dec;
    logic        m_valid_reg, m_valid_next;
    logic        kind_reg, kind_next;
    hdr_fields_t out_hdr_reg, out_hdr_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic        last_reg, last_next;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign pay_mode = in_payload_reg && (remaining_reg != '0);
    assign hdr_take = accept && !pay_mode;
    assign produce  = pay_mode || opcode_slot;
    assign remaining_dec = remaining_reg - 32'd1;

    lpmd_hdr_capture u_hdr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (hdr_take),
        .data_byte   (s_data_byte),
        .hdr         (hdr),
        .opcode_slot (opcode_slot)
    );

    always_comb begin
        in_payload_next = in_payload_reg;
        remaining_next  = remaining_reg;
        if (accept) begin
            if (pay_mode) begin
                remaining_next  = remaining_dec;
                in_payload_next = (remaining_dec != '0);
            end else if (opcode_slot) begin
                remaining_next  = hdr.payload_length;
                in_payload_next = (hdr.payload_length != '0);
            end else begin
                in_payload_next = 1'b0;
            end
        end
    end

    // Load the output register on a producing transaction, otherwise drain it.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        out_hdr_next = out_hdr_reg;
        opcode_next  = opcode_reg;
        pbyte_next   = pbyte_reg;
        last_next    = last_reg;
        if (accept && produce) begin
            m_valid_next = 1'b1;
            if (pay_mode) begin
                kind_next    = KIND_PAYLOAD;
                out_hdr_next = '0;
                opcode_next  = '0;
                pbyte_next   = s_data_byte;
                last_next    = (remaining_dec == '0);
            end else begin
                kind_next    = KIND_HEADER;
                out_hdr_next = hdr;
                opcode_next  = s_data_byte;
                pbyte_next   = '0;
                last_next    = (hdr.payload_length == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg <= 1'b0;
            remaining_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            in_payload_reg <= in_payload_next;
            remaining_reg  <= remaining_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        out_hdr_reg <= out_hdr_next;
        opcode_reg  <= opcode_next;
        pbyte_reg   <= pbyte_next;
        last_reg    <= last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_attempt        = out_hdr_reg.attempt;
    assign m_tracked        = out_hdr_reg.tracked;
    assign m_reliable       = out_hdr_reg.reliable;
    assign m_source_id      = out_hdr_reg.source_id;
    assign m_sequence_res   = out_hdr_reg.sequence_num;
    assign m_payload_length = out_hdr_reg.payload_length;
    assign m_opcode         = opcode_reg;
    assign m_payload_byte   = pbyte_reg;
    assign m_last           = last_reg;

    `ASSERT_PROP(a_payload_count_nonzero, in_payload_reg |-> (remaining_reg != '0), "empty count")
    `ASSERT_PROP(a_final_byte_last, (accept && pay_mode && remaining_reg == 32'd1) |=> (m_valid && m_last && m_kind == KIND_PAYLOAD), "last missing")
    `ASSERT_PROP(a_opcode_header_result, (accept && !pay_mode && opcode_slot) |=> (m_valid && m_kind == KIND_HEADER), "no header result")
    `ASSERT_PROP(a_payload_entry, $rose(in_payload_reg) |-> (m_valid && m_kind == KIND_HEADER && !m_last), "bad payload entry")
    `ASSERT_ALWAYS(a_ready_when_empty, !m_valid_reg |-> s_ready, "input stalled while empty")

endmodule
